// ===== rtl/vphp_pkg.sv =====
// Shared constants, types and the CRC-16/ARC byte update for the header parser.
package vphp_pkg;

  localparam int HEADER_BYTES = 30;
  localparam int CRC_SPAN     = 28;
  localparam int POS_W        = 5;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 32;

  localparam logic [7:0]  CHANNEL_MAX   = 8'd3;
  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'h0000;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_MAGIC      = 3'd1,
    STS_VERSION    = 3'd2,
    STS_CHANNEL    = 3'd3,
    STS_FRAGMENT   = 3'd4,
    STS_CRC        = 3'd5,
    STS_AU_SIZE    = 3'd6,
    STS_FRAG_TOTAL = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    REG_EXPECTED_MAGIC   = 2'd0,
    REG_EXPECTED_VERSION = 2'd1,
    REG_AU_SIZE_LIMIT    = 2'd2,
    REG_FRAG_TOTAL_LIMIT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] expected_magic;
    logic [7:0]  expected_version;
    logic [31:0] au_size_limit;
    logic [15:0] frag_total_limit;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] hdr_byte;
    logic       start;
  } in_item_t;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY_REFL;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// ===== rtl/vphp_cfg_regs.sv =====
// APB-style configuration registers of the header parser.
module vphp_cfg_regs
  import vphp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = cfg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_magic   <= 16'h0000;
      cfg_r.expected_version <= 8'h01;
      cfg_r.au_size_limit    <= 32'hFFFF_FFFF;
      cfg_r.frag_total_limit <= 16'hFFFF;
    end else if (wr_en) begin
      case (idx)
        REG_EXPECTED_MAGIC:   cfg_r.expected_magic   <= pwdata[15:0];
        REG_EXPECTED_VERSION: cfg_r.expected_version <= pwdata[7:0];
        REG_AU_SIZE_LIMIT:    cfg_r.au_size_limit    <= pwdata;
        REG_FRAG_TOTAL_LIMIT: cfg_r.frag_total_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_EXPECTED_MAGIC:   prdata = {16'h0000, cfg_r.expected_magic};
      REG_EXPECTED_VERSION: prdata = {24'h000000, cfg_r.expected_version};
      REG_AU_SIZE_LIMIT:    prdata = cfg_r.au_size_limit;
      REG_FRAG_TOTAL_LIMIT: prdata = {16'h0000, cfg_r.frag_total_limit};
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== rtl/vphp_in_stage.sv =====
// Input register of the header parser: holds one accepted byte transaction.
module vphp_in_stage
  import vphp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_header_byte,
  input  logic       in_start_flag,
  input  logic       take,
  output in_item_t   item
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       start_r;

  assign in_ready = !valid_r || take;
  assign item     = '{valid: valid_r, hdr_byte: byte_r, start: start_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r  <= in_header_byte;
      start_r <= in_start_flag;
    end
  end

endmodule

// ===== rtl/vphp_parser.sv =====
// Parse state, header byte store, CRC, checks and the result register.
module vphp_parser
  import vphp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    item,
  input  cfg_t        cfg,
  output logic        take,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_channel,
  output logic [31:0] out_frame_number,
  output logic [15:0] out_fragment_index,
  output logic [15:0] out_fragment_count,
  output logic [7:0]  out_keyframe,
  output logic [7:0]  out_nal_kind,
  output logic [15:0] out_nal_count,
  output logic [63:0] out_timestamp,
  output logic [31:0] out_unit_size
);

  localparam int STORE_BYTES = HEADER_BYTES - 1;

  logic             active_r, active_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       hdr_r [0:STORE_BYTES-1];

  logic             act;
  logic [POS_W-1:0] pos_eff;
  logic [15:0]      crc_eff;
  logic             wr_en;
  logic             emit;
  logic             load;

  logic [15:0] magic, fr_index, fr_count, rx_crc;
  status_t     status;

  logic        out_valid_r;
  status_t     status_r;
  logic [7:0]  channel_r, keyframe_r, nal_kind_r;
  logic [31:0] frame_r, unit_size_r;
  logic [15:0] fr_index_r, fr_count_r, nal_count_r;
  logic [63:0] timestamp_r;

  // A start flag restarts the parse with this byte as byte 0.
  always_comb begin
    if (item.start) begin
      act     = 1'b1;
      pos_eff = '0;
      crc_eff = CRC_INIT;
    end else begin
      act     = active_r;
      pos_eff = pos_r;
      crc_eff = crc_r;
    end
  end

  assign emit  = item.valid && act && (pos_eff == POS_W'(HEADER_BYTES - 1));
  assign take  = item.valid && (!emit || !out_valid_r || out_ready);
  assign wr_en = take && act && (pos_eff < POS_W'(STORE_BYTES));
  assign load  = take && emit;

  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    if (take && act) begin
      if (pos_eff >= POS_W'(HEADER_BYTES)) begin
        active_nxt = 1'b0;
        pos_nxt    = '0;
      end else begin
        crc_nxt = (pos_eff < POS_W'(CRC_SPAN)) ? crc16_update(crc_eff, item.hdr_byte)
                                               : crc_eff;
        if (pos_eff == POS_W'(HEADER_BYTES - 1)) begin
          active_nxt = 1'b0;
          pos_nxt    = '0;
        end else begin
          active_nxt = 1'b1;
          pos_nxt    = pos_eff + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= '0;
      crc_r    <= CRC_INIT;
    end else begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STORE_BYTES; i++) begin
      if (wr_en && (pos_eff == POS_W'(i))) hdr_r[i] <= item.hdr_byte;
    end
  end

  assign magic    = {hdr_r[0], hdr_r[1]};
  assign fr_index = {hdr_r[8], hdr_r[9]};
  assign fr_count = {hdr_r[10], hdr_r[11]};
  // Last CRC byte is the one in flight.
  assign rx_crc   = {hdr_r[28], item.hdr_byte};

  always_comb begin
    if (magic != cfg.expected_magic)                         status = STS_MAGIC;
    else if (hdr_r[2] != cfg.expected_version)               status = STS_VERSION;
    else if (hdr_r[3] > CHANNEL_MAX)                         status = STS_CHANNEL;
    else if (fr_count == 16'h0000 || fr_index >= fr_count)   status = STS_FRAGMENT;
    else if (crc_r != rx_crc)                                status = STS_CRC;
    else if ({hdr_r[24], hdr_r[25], hdr_r[26], hdr_r[27]} > cfg.au_size_limit)
                                                             status = STS_AU_SIZE;
    else if (fr_count > cfg.frag_total_limit)                status = STS_FRAG_TOTAL;
    else                                                     status = STS_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r     <= status;
      channel_r    <= hdr_r[3];
      frame_r      <= {hdr_r[4], hdr_r[5], hdr_r[6], hdr_r[7]};
      fr_index_r   <= fr_index;
      fr_count_r   <= fr_count;
      keyframe_r   <= hdr_r[12];
      nal_kind_r   <= hdr_r[13];
      nal_count_r  <= {hdr_r[14], hdr_r[15]};
      timestamp_r  <= {hdr_r[16], hdr_r[17], hdr_r[18], hdr_r[19],
                       hdr_r[20], hdr_r[21], hdr_r[22], hdr_r[23]};
      unit_size_r  <= {hdr_r[24], hdr_r[25], hdr_r[26], hdr_r[27]};
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_channel        = channel_r;
  assign out_frame_number   = frame_r;
  assign out_fragment_index = fr_index_r;
  assign out_fragment_count = fr_count_r;
  assign out_keyframe       = keyframe_r;
  assign out_nal_kind       = nal_kind_r;
  assign out_nal_count      = nal_count_r;
  assign out_timestamp      = timestamp_r;
  assign out_unit_size      = unit_size_r;

endmodule

// ===== rtl/video_packet_header_parser_top.sv =====
// Throughput: one header byte per cycle, set by the single input-to-result register pass;
// byte 29 waits in the input register only while an earlier result is not yet taken.
// The result of byte 29 is valid once that byte has passed the input register and then
// the result register; other bytes give no result.
// Parse state, CRC and result valid clear on synchronous active-low reset;
// configuration registers return to their reset values; the byte store is not cleared.
module video_packet_header_parser_top
  import vphp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_header_byte,
  input  logic                  in_start_flag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [7:0]            out_channel,
  output logic [31:0]           out_frame_number,
  output logic [15:0]           out_fragment_index,
  output logic [15:0]           out_fragment_count,
  output logic [7:0]            out_keyframe,
  output logic [7:0]            out_nal_kind,
  output logic [15:0]           out_nal_count,
  output logic [63:0]           out_timestamp,
  output logic [31:0]           out_unit_size,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg;
  in_item_t item;
  logic     take;

  vphp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vphp_in_stage u_in (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_header_byte (in_header_byte),
    .in_start_flag  (in_start_flag),
    .take           (take),
    .item           (item)
  );

  vphp_parser u_parser (
    .clk                (clk),
    .rst_n              (rst_n),
    .item               (item),
    .cfg                (cfg),
    .take               (take),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_channel        (out_channel),
    .out_frame_number   (out_frame_number),
    .out_fragment_index (out_fragment_index),
    .out_fragment_count (out_fragment_count),
    .out_keyframe       (out_keyframe),
    .out_nal_kind       (out_nal_kind),
    .out_nal_count      (out_nal_count),
    .out_timestamp      (out_timestamp),
    .out_unit_size      (out_unit_size)
  );

endmodule
